// ===== src/ts_frame_reassembler_assert.svh =====
// Assertion macros used by the reassembler.
// Each macro samples on clk and is held off while arst_n is low.
`ifndef TS_FRAME_REASSEMBLER_ASSERT_SVH
`define TS_FRAME_REASSEMBLER_ASSERT_SVH

// Same-cycle implication.
`define TSFR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tsfr_pkg.sv =====
package tsfr_pkg;

	localparam int DEF_SLOT_COUNT = 8;
	localparam int DEF_SLOT_BYTES = 16384;

	localparam int CHUNK_BYTES = 179;
	localparam int PKT_LAST    = 187;
	localparam int SIZE_LEN    = 2;
	localparam int PID_W       = 13;
	localparam int PID_RESET   = 64;
	localparam int WOFF_W      = 16;

	// ceil((size + 2) / 179) = ((size + 180) * EXP_RECIP) >> EXP_SHIFT for 17-bit operands
	localparam int EXP_RECIP   = 187455;
	localparam int EXP_SHIFT   = 25;

	localparam logic [2:0] STAT_PENDING  = 3'd0;
	localparam logic [2:0] STAT_COMPLETE = 3'd1;
	localparam logic [2:0] STAT_BAD_PID  = 3'd2;
	localparam logic [2:0] STAT_TOO_OLD  = 3'd3;
	localparam logic [2:0] STAT_READ     = 3'd4;
	localparam logic [2:0] STAT_NONE     = 3'd0;

	typedef logic [PID_W-1:0] pid_t;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  stream_byte;
		logic        packet_first;
		logic [2:0]  read_slot;
		logic [13:0] read_offset;
	} tsfr_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  slot_used;
		logic [31:0] frame_number;
		logic [15:0] frame_size;
		logic [7:0]  read_data;
	} tsfr_out_t;

	typedef struct packed {
		logic [31:0] frame;
		logic [7:0]  received;
		logic [15:0] expected;
		logic [15:0] total_bytes;
	} slot_rec_t;

	typedef struct packed {
		logic choose;
		logic finish;
		logic start_flag;
	} slot_cmd_t;

	typedef struct packed {
		logic done;
		logic ok;
		logic complete;
	} slot_rsp_t;

endpackage

// ===== src/tsfr_stream_if.sv =====
interface tsfr_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/tsfr_ram.sv =====
module tsfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/tsfr_slot_ctrl.sv =====
module tsfr_slot_ctrl import tsfr_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  slot_cmd_t                     cmd,
	input  logic [31:0]                   frame,
	input  logic [$clog2(SLOT_COUNT)-1:0] slot_in,
	input  logic [15:0]                   size,
	input  logic [15:0]                   expected,
	output slot_rsp_t                     rsp,
	output logic [$clog2(SLOT_COUNT)-1:0] slot_out,
	output logic [15:0]                   total
);
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int POS_W  = $clog2(SLOT_COUNT + 1);
	localparam int REC_W  = $bits(slot_rec_t);
	localparam logic [POS_W-1:0] POS_END = POS_W'(SLOT_COUNT);

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_SCAN = 3'd1;
	localparam logic [2:0] C_DEC  = 3'd2;
	localparam logic [2:0] C_FRD  = 3'd3;
	localparam logic [2:0] C_FWB  = 3'd4;

	typedef logic [SLOT_COUNT-1:0][SLOT_W-1:0] ord_t;

	// move the list entry at position a to just before position b (b may be the end)
	function automatic ord_t list_move(ord_t o, logic [POS_W-1:0] a, logic [POS_W-1:0] b);
		ord_t r;
		logic [SLOT_W-1:0] v;
		r = o;
		v = o[a[SLOT_W-1:0]];
		for (int k = 0; k < SLOT_COUNT; k++) begin
			if (a < b) begin
				if (POS_W'(k) >= a && POS_W'(k + 1) < b) r[k] = o[(k + 1) % SLOT_COUNT];
				if (POS_W'(k + 1) == b) r[k] = v;
			end else if (a > b) begin
				if (POS_W'(k) > b && POS_W'(k) <= a) r[k] = o[(k + SLOT_COUNT - 1) % SLOT_COUNT];
				if (POS_W'(k) == b) r[k] = v;
			end
		end
		return r;
	endfunction

	logic [2:0]            st_q;
	ord_t                  order_q, ord_nxt;
	logic [SLOT_COUNT-1:0] busy_q;
	logic [31:0]           frame_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  start_q;
	logic [15:0]           size_q, exp_q;
	logic [POS_W-1:0]      sc_p_q, sc_pos_s1;
	logic                  sc_v_s1;
	logic [SLOT_W-1:0]     sc_slot_s1;
	logic                  hit_q;
	logic [SLOT_W-1:0]     hit_slot_q, un_slot_q;
	logic [POS_W-1:0]      un_pos_q, nx_pos_q;

	logic                  ram_we, ram_re;
	logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
	logic [REC_W-1:0]      ram_wdata, ram_rdata;
	slot_rec_t             rec_rd, rec_upd, rec_new;
	logic [SLOT_W-1:0]     dec_s;
	logic                  too_old, cmp;
	logic [POS_W-1:0]      fpos;

	assign rec_rd = slot_rec_t'(ram_rdata);

	tsfr_ram #(.WIDTH(REC_W), .DEPTH(SLOT_COUNT)) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = order_q[sc_p_q[SLOT_W-1:0]];
		if (st_q == C_SCAN && sc_p_q < POS_END) ram_re = 1'b1;
		if (st_q == C_FRD) begin
			ram_re    = 1'b1;
			ram_raddr = slot_q;
		end
	end

	always_comb begin
		fpos = '0;
		for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
			if (order_q[k] == slot_q) fpos = POS_W'(k);
		end
	end

	assign too_old = !hit_q && un_pos_q == POS_END && nx_pos_q == '0;
	assign dec_s   = hit_q ? hit_slot_q : (un_pos_q == POS_END ? order_q[0] : un_slot_q);

	always_comb begin
		rec_upd = rec_rd;
		if (start_q) begin
			rec_upd.total_bytes = size_q;
			rec_upd.expected    = exp_q;
		end
		rec_upd.received = rec_rd.received + 8'd1;
	end
	assign cmp   = rec_upd.expected != '0 && rec_upd.expected == {8'd0, rec_upd.received};
	assign total = rec_upd.total_bytes;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		rec_new   = '0;
		ord_nxt   = order_q;
		rsp       = '0;
		slot_out  = slot_q;
		unique case (st_q)
			C_DEC: begin
				rsp.done = 1'b1;
				if (hit_q) begin
					rsp.ok   = 1'b1;
					slot_out = hit_slot_q;
				end else if (!too_old) begin
					rsp.ok        = 1'b1;
					slot_out      = dec_s;
					ram_we        = 1'b1;
					ram_waddr     = dec_s;
					rec_new.frame = frame_q;
					if (un_pos_q == POS_END) ord_nxt = list_move(order_q, '0, nx_pos_q);
					else if (nx_pos_q != POS_END) ord_nxt = list_move(order_q, un_pos_q, nx_pos_q);
				end
			end
			C_FWB: begin
				rsp.done     = 1'b1;
				rsp.ok       = 1'b1;
				rsp.complete = cmp;
				ram_we       = 1'b1;
				if (cmp) ord_nxt = list_move(order_q, fpos, POS_END);
				else rec_new = rec_upd;
			end
			C_IDLE, C_SCAN, C_FRD: begin
			end
			default: begin
			end
		endcase
	end
	assign ram_wdata = REC_W'(rec_new);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= C_IDLE;
			busy_q   <= '0;
			sc_p_q   <= '0;
			sc_v_s1  <= 1'b0;
			hit_q    <= 1'b0;
			un_pos_q <= POS_END;
			nx_pos_q <= POS_END;
			slot_q   <= '0;
			for (int k = 0; k < SLOT_COUNT; k++) order_q[k] <= SLOT_W'(k);
		end else begin
			order_q <= ord_nxt;
			unique case (st_q)
				C_IDLE: begin
					if (cmd.choose) begin
						frame_q  <= frame;
						sc_p_q   <= '0;
						sc_v_s1  <= 1'b0;
						hit_q    <= 1'b0;
						un_pos_q <= POS_END;
						nx_pos_q <= POS_END;
						st_q     <= C_SCAN;
					end else if (cmd.finish) begin
						slot_q  <= slot_in;
						start_q <= cmd.start_flag;
						size_q  <= size;
						exp_q   <= expected;
						st_q    <= C_FRD;
					end
				end
				C_SCAN: begin
					if (sc_p_q < POS_END) begin
						sc_v_s1    <= 1'b1;
						sc_pos_s1  <= sc_p_q;
						sc_slot_s1 <= order_q[sc_p_q[SLOT_W-1:0]];
						sc_p_q     <= sc_p_q + 1'b1;
					end else begin
						sc_v_s1 <= 1'b0;
					end
					if (sc_v_s1) begin
						if (busy_q[sc_slot_s1]) begin
							if (rec_rd.frame == frame_q && !hit_q) begin
								hit_q      <= 1'b1;
								hit_slot_q <= sc_slot_s1;
							end
							if (frame_q < rec_rd.frame && nx_pos_q == POS_END) nx_pos_q <= sc_pos_s1;
						end else if (un_pos_q == POS_END) begin
							un_pos_q  <= sc_pos_s1;
							un_slot_q <= sc_slot_s1;
						end
						if (sc_pos_s1 == POS_END - 1'b1) st_q <= C_DEC;
					end
				end
				C_DEC: begin
					if (!hit_q && !too_old) busy_q[dec_s] <= 1'b1;
					slot_q <= slot_out;
					st_q   <= C_IDLE;
				end
				C_FRD: st_q <= C_FWB;
				C_FWB: begin
					if (cmp) busy_q[slot_q] <= 1'b0;
					st_q <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end
endmodule

// ===== src/ts_frame_reassembler.sv =====
// Transport packet frame reassembler.
// cfg : expected PID write; always ready, used at the next packet byte 2.
// pkt : one request per beat. A stream request carries one packet byte
//       (packet_first marks byte 0 of a 188-byte packet); a read request
//       addresses one byte of slot memory by read_slot and read_offset.
// res : one result per packet (status at the last byte) and one per read.
// Throughput: stream bytes go in at one per cycle while pkt is not held off.
// On the last frame-number byte of a packet with a good PID, the slot list
// is scanned through the slot record memory, one slot per cycle; pkt is held
// off until the search ends. The last byte of a packet that holds a slot
// starts a read-modify-write of its slot record (read, then update and
// write back); pkt is held off until the write-back puts its status on res.
// A read request waits on the registered read port of the payload memory:
// its result is registered in the next cycle, while pkt is held off.
// Reset: all slots free, list in slot order, PID 64, no packet in progress.
// Payload memory is not cleared; only bytes written may be read back.
// Stall: res holds its result until taken. Requests that cause no result are
// still accepted while a result waits; a request that would end in a result
// waits until the output register is free.
module ts_frame_reassembler import tsfr_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
	input  logic         clk,
	input  logic         arst_n,
	tsfr_stream_if.sink   cfg,
	tsfr_stream_if.sink   pkt,
	tsfr_stream_if.source res
);
	localparam int SLOT_W = $clog2(SLOT_COUNT);
	localparam int MEM_D  = SLOT_COUNT * SLOT_BYTES;
	localparam int MEM_AW = $clog2(MEM_D);

	localparam logic [1:0] S_RUN   = 2'd0;
	localparam logic [1:0] S_RDATA = 2'd1;
	localparam logic [1:0] S_SLOT  = 2'd2;
	localparam logic [1:0] S_END   = 2'd3;

	logic [1:0]        st_q;
	pid_t              pid_q;
	logic [7:0]        pos_q;
	logic [7:0]        hdr1_q;
	logic [31:0]       frame_q;
	logic [15:0]       size_q, exp_q;
	logic [WOFF_W-1:0] woff_q;
	logic [2:0]        verdict_q;
	logic              chosen_q;
	logic [SLOT_W-1:0] cur_slot_q;
	logic [MEM_AW-1:0] slot_base_q;
	logic              rd_zero_s1;
	logic [2:0]        rd_slot_s1;
	logic              res_valid_q;
	tsfr_out_t         res_q;

	tsfr_in_t          in_d;
	logic [7:0]        b, i;
	logic              is_rd, active, ends, out_free, pkt_acc, res_load;
	tsfr_out_t         res_nxt;
	logic              rd_in_range, mem_we, mem_re;
	logic [MEM_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_rdata;
	logic [WOFF_W-1:0] woff_m2;
	logic [34:0]       exp_prod;
	slot_cmd_t         scmd;
	slot_rsp_t         srsp;
	logic [SLOT_W-1:0] s_slot;
	logic [15:0]       s_total;

	assign in_d   = pkt.data;
	assign b      = in_d.stream_byte;
	assign is_rd  = in_d.req_type;
	assign i      = in_d.packet_first ? 8'd0 : pos_q;
	assign active = in_d.packet_first || pos_q != 8'd0;
	assign ends   = !is_rd && active && i == 8'(PKT_LAST);

	// a request that ends in a result needs the output register free
	assign out_free  = !res_valid_q || res.ready;
	assign pkt.ready = st_q == S_RUN && (out_free || (!is_rd && !ends));
	assign pkt_acc   = pkt.valid && pkt.ready;
	assign cfg.ready = 1'b1;

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	// payload placement: offset = index * 179 - 2 + t, tracked as woff_q = index * 179 + t
	assign woff_m2 = woff_q - WOFF_W'(SIZE_LEN);
	assign mem_we  = pkt_acc && !is_rd && active && i >= 8'd9 && chosen_q
		&& woff_q >= WOFF_W'(SIZE_LEN) && 17'(woff_m2) < 17'(SLOT_BYTES);
	assign mem_waddr = slot_base_q + MEM_AW'(woff_m2);

	assign rd_in_range = int'(in_d.read_slot) < SLOT_COUNT && int'(in_d.read_offset) < SLOT_BYTES;
	assign mem_re      = pkt_acc && is_rd && rd_in_range;
	assign mem_raddr   = MEM_AW'(MEM_AW'(in_d.read_slot) * MEM_AW'(SLOT_BYTES))
		+ MEM_AW'(in_d.read_offset);

	// expected packet count = ceil((size + 2) / 179) by reciprocal multiply
	assign exp_prod = 35'(17'(size_q) + 17'(SIZE_LEN + CHUNK_BYTES - 1)) * 35'(EXP_RECIP);

	tsfr_ram #(.WIDTH(8), .DEPTH(MEM_D)) u_payload_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (b),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// slot search kicks off on the last frame-number byte, finish on the last packet byte
	always_comb begin
		scmd            = '0;
		scmd.choose     = pkt_acc && !is_rd && active && i == 8'd7 && verdict_q == STAT_NONE;
		scmd.finish     = pkt_acc && ends && verdict_q == STAT_NONE && chosen_q;
		scmd.start_flag = hdr1_q[6];
	end

	tsfr_slot_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_slot_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (scmd),
		.frame    ({b, frame_q[23:0]}),
		.slot_in  (cur_slot_q),
		.size     (size_q),
		.expected (exp_q),
		.rsp      (srsp),
		.slot_out (s_slot),
		.total    (s_total)
	);

	// result selection
	always_comb begin
		res_load = 1'b0;
		res_nxt  = '0;
		unique case (st_q)
			S_RUN: begin
				if (pkt_acc && ends && !scmd.finish) begin
					res_load             = 1'b1;
					res_nxt.status       = verdict_q != STAT_NONE ? verdict_q : STAT_BAD_PID;
					res_nxt.frame_number = frame_q;
				end
			end
			S_RDATA: begin
				res_load          = 1'b1;
				res_nxt.status    = STAT_READ;
				res_nxt.slot_used = rd_slot_s1;
				res_nxt.read_data = rd_zero_s1 ? 8'd0 : mem_rdata;
			end
			S_END: begin
				if (srsp.done) begin
					res_load             = 1'b1;
					res_nxt.status       = srsp.complete ? STAT_COMPLETE : STAT_PENDING;
					res_nxt.slot_used    = 3'(s_slot);
					res_nxt.frame_number = frame_q;
					res_nxt.frame_size   = srsp.complete ? s_total : 16'd0;
				end
			end
			S_SLOT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_nxt;
		if (pkt_acc && is_rd) begin
			rd_zero_s1 <= !rd_in_range;
			rd_slot_s1 <= in_d.read_slot;
		end
		if (pkt_acc && !is_rd && active) begin
			if (i == 8'd1) hdr1_q <= b;
			if (i >= 8'd4 && i <= 8'd7) frame_q[8*(i[1:0]) +: 8] <= b;
			if (i == 8'd8) woff_q <= WOFF_W'(b) * WOFF_W'(CHUNK_BYTES);
			else if (i >= 8'd9) woff_q <= woff_q + 1'b1;
			if (i == 8'd9) size_q[7:0] <= b;
			if (i == 8'd10) size_q[15:8] <= b;
			if (i == 8'd11) exp_q <= 16'(exp_prod >> EXP_SHIFT);
		end
		if (st_q == S_SLOT && srsp.done && srsp.ok) begin
			cur_slot_q  <= s_slot;
			slot_base_q <= MEM_AW'(MEM_AW'(s_slot) * MEM_AW'(SLOT_BYTES));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_RUN;
			pid_q       <= PID_W'(PID_RESET);
			pos_q       <= '0;
			verdict_q   <= STAT_NONE;
			chosen_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) pid_q <= cfg.data;
			if (res_load) res_valid_q <= 1'b1;
			else if (res.ready) res_valid_q <= 1'b0;
			unique case (st_q)
				S_RUN: begin
					if (pkt_acc && is_rd) begin
						st_q <= S_RDATA;
					end else if (pkt_acc && active) begin
						// drop any packet in progress on a new first byte
						if (in_d.packet_first) begin
							verdict_q <= STAT_NONE;
							chosen_q  <= 1'b0;
						end
						if (i == 8'd2 && {hdr1_q[4:0], b} != pid_q) verdict_q <= STAT_BAD_PID;
						if (scmd.choose) st_q <= S_SLOT;
						if (ends) begin
							pos_q    <= '0;
							chosen_q <= 1'b0;
							if (scmd.finish) st_q <= S_END;
						end else begin
							pos_q <= i + 8'd1;
						end
					end
				end
				S_RDATA: st_q <= S_RUN;
				S_SLOT: begin
					if (srsp.done) begin
						if (srsp.ok) chosen_q <= 1'b1;
						else verdict_q <= STAT_TOO_OLD;
						st_q <= S_RUN;
					end
				end
				S_END: begin
					if (srsp.done) st_q <= S_RUN;
				end
				default: st_q <= S_RUN;
			endcase
		end
	end

`include "ts_frame_reassembler_assert.svh"

	`TSFR_ASSERT_SAME(a_res_free, res_load, !res_valid_q || res.ready, "result overwritten")
	`TSFR_ASSERT_SAME(a_wr_slot, mem_we, chosen_q && st_q == S_RUN, "payload write without slot")
	`TSFR_ASSERT_NEXT(a_read_data, pkt_acc && is_rd, st_q == S_RDATA, "read request lost")

endmodule
